@@ rtl/udr_pkg.sv @@
// shared types, codes and helpers for the diagnostic responder
`timescale 1ns / 1ps

package udr_pkg;

  localparam int VALUE_SLOTS = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int REPLY_MAX   = 7;

  // item operations
  localparam logic [1:0] OP_REQUEST = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_UPDATE  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_DID_FIRST  = 2'd0;
  localparam logic [1:0] REG_DID_SECOND = 2'd1;
  localparam logic [1:0] REG_DID_THIRD  = 2'd2;
  localparam logic [1:0] REG_TIMEOUT    = 2'd3;

  // service identifiers
  localparam logic [7:0] SID_SESSION_CTRL = 8'h10;
  localparam logic [7:0] SID_ECU_RESET    = 8'h11;
  localparam logic [7:0] SID_READ_DID     = 8'h22;
  localparam logic [7:0] SID_TESTER_PRES  = 8'h3E;

  // reply header bytes
  localparam logic [7:0] RSP_NEGATIVE     = 8'h7F;
  localparam logic [7:0] RSP_SESSION_CTRL = 8'h50;
  localparam logic [7:0] RSP_ECU_RESET    = 8'h51;
  localparam logic [7:0] RSP_READ_DID     = 8'h62;
  localparam logic [7:0] RSP_TESTER_PRES  = 8'h7E;

  // negative response codes
  localparam logic [7:0] NRC_SERVICE    = 8'h11;
  localparam logic [7:0] NRC_SUBFUNC    = 8'h12;
  localparam logic [7:0] NRC_LENGTH     = 8'h13;
  localparam logic [7:0] NRC_CONDITIONS = 8'h22;
  localparam logic [7:0] NRC_RANGE      = 8'h31;

  localparam logic [2:0]  DEFAULT_SESSION = 3'd1;
  localparam logic [7:0]  TOP_SESSION     = 8'd4;
  localparam logic [15:0] TIMEOUT_RESET   = 16'd5000;

  // one queued reply, data[0] goes out first
  typedef struct packed {
    logic [REPLY_MAX-1:0][7:0] data;
    logic [2:0]                byte_cnt;
    logic                      positive;
  } reply_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic   valid;
    reply_t reply;
  } queue_head_t;

  function automatic reply_t make_negative(input logic [7:0] sid, input logic [7:0] code);
    reply_t r;
    r          = '0;
    r.data[0]  = RSP_NEGATIVE;
    r.data[1]  = sid;
    r.data[2]  = code;
    r.byte_cnt = 3'd3;
    r.positive = 1'b0;
    return r;
  endfunction

endpackage

@@ rtl/udr_front.sv @@
// front end: accepts items, keeps session and value state, builds replies
`timescale 1ns / 1ps

module udr_front #(
  parameter int VALUE_SLOTS = udr_pkg::VALUE_SLOTS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_wdata,
  input  logic             accept,
  input  logic [1:0]       operation,
  input  logic [7:0]       req_sid,
  input  logic [7:0]       req_byte_one,
  input  logic [7:0]       req_byte_two,
  input  logic [11:0]      request_length,
  input  logic [1:0]       value_slot,
  input  logic [31:0]      value_bits,
  input  logic             value_valid,
  output logic             push,
  output udr_pkg::reply_t  push_reply
);

  logic [15:0] did_first_r, did_second_r, did_third_r, timeout_r;
  logic [2:0]  session_r, session_nxt;
  logic [15:0] quiet_r, quiet_nxt, quiet_inc;
  logic [31:0] slot_value_r [VALUE_SLOTS];
  logic [VALUE_SLOTS-1:0] slot_valid_r;

  logic [15:0] did;
  logic        hit_found;
  logic [1:0]  hit;
  logic        rd_valid;
  logic [31:0] rd_value;
  udr_pkg::reply_t rep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      did_first_r  <= '0;
      did_second_r <= '0;
      did_third_r  <= '0;
      timeout_r    <= udr_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        udr_pkg::REG_DID_FIRST:  did_first_r  <= cfg_wdata;
        udr_pkg::REG_DID_SECOND: did_second_r <= cfg_wdata;
        udr_pkg::REG_DID_THIRD:  did_third_r  <= cfg_wdata;
        udr_pkg::REG_TIMEOUT:    timeout_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // identifier map scan, stops at the first empty entry
  assign did = {req_byte_one, req_byte_two};

  always_comb begin
    hit_found = 1'b0;
    hit       = 2'd0;
    if (did_first_r != '0) begin
      if (did_first_r == did) begin
        hit_found = 1'b1;
        hit       = 2'd0;
      end else if (did_second_r != '0) begin
        if (did_second_r == did) begin
          hit_found = 1'b1;
          hit       = 2'd1;
        end else if (did_third_r != '0 && did_third_r == did) begin
          hit_found = 1'b1;
          hit       = 2'd2;
        end
      end
    end
  end

  // slot read; a hit beyond the slot count reads as not available
  always_comb begin
    rd_valid = 1'b0;
    rd_value = '0;
    for (int i = 0; i < VALUE_SLOTS; i++) begin
      if (32'(hit) == i) begin
        rd_valid = slot_valid_r[i];
        rd_value = slot_value_r[i];
      end
    end
  end

  assign quiet_inc = (quiet_r == 16'hFFFF) ? quiet_r : quiet_r + 16'd1;

  always_comb begin
    rep         = '0;
    session_nxt = session_r;
    quiet_nxt   = quiet_r;
    if (accept) begin
      unique case (operation)
        udr_pkg::OP_REQUEST: begin
          if (request_length != '0) begin
            unique case (req_sid)
              udr_pkg::SID_SESSION_CTRL: begin
                if (request_length < 12'd2) begin
                  rep = udr_pkg::make_negative(req_sid, udr_pkg::NRC_LENGTH);
                end else if (req_byte_one == '0 || req_byte_one > udr_pkg::TOP_SESSION) begin
                  rep = udr_pkg::make_negative(req_sid, udr_pkg::NRC_SUBFUNC);
                end else begin
                  session_nxt  = req_byte_one[2:0];
                  quiet_nxt    = '0;
                  rep.data[0]  = udr_pkg::RSP_SESSION_CTRL;
                  rep.data[1]  = req_byte_one;
                  rep.byte_cnt = 3'd2;
                  rep.positive = 1'b1;
                end
              end
              udr_pkg::SID_ECU_RESET: begin
                if (request_length < 12'd2) begin
                  rep = udr_pkg::make_negative(req_sid, udr_pkg::NRC_LENGTH);
                end else if (req_byte_one != 8'h01 && req_byte_one != 8'h03) begin
                  rep = udr_pkg::make_negative(req_sid, udr_pkg::NRC_SUBFUNC);
                end else begin
                  rep.data[0]  = udr_pkg::RSP_ECU_RESET;
                  rep.data[1]  = req_byte_one;
                  rep.byte_cnt = 3'd2;
                  rep.positive = 1'b1;
                end
              end
              udr_pkg::SID_READ_DID: begin
                if (request_length < 12'd3) begin
                  rep = udr_pkg::make_negative(req_sid, udr_pkg::NRC_LENGTH);
                end else if (!hit_found) begin
                  rep = udr_pkg::make_negative(req_sid, udr_pkg::NRC_RANGE);
                end else if (!rd_valid) begin
                  rep = udr_pkg::make_negative(req_sid, udr_pkg::NRC_CONDITIONS);
                end else begin
                  rep.data[0]  = udr_pkg::RSP_READ_DID;
                  rep.data[1]  = req_byte_one;
                  rep.data[2]  = req_byte_two;
                  rep.data[3]  = rd_value[31:24];
                  rep.data[4]  = rd_value[23:16];
                  rep.data[5]  = rd_value[15:8];
                  rep.data[6]  = rd_value[7:0];
                  rep.byte_cnt = 3'd7;
                  rep.positive = 1'b1;
                end
              end
              udr_pkg::SID_TESTER_PRES: begin
                if (request_length < 12'd2) begin
                  rep = udr_pkg::make_negative(req_sid, udr_pkg::NRC_LENGTH);
                end else begin
                  quiet_nxt = '0;
                  // other sub-functions are answered with silence
                  if (req_byte_one == 8'h01) begin
                    rep.data[0]  = udr_pkg::RSP_TESTER_PRES;
                    rep.data[1]  = 8'h01;
                    rep.byte_cnt = 3'd2;
                    rep.positive = 1'b1;
                  end
                end
              end
              default: rep = udr_pkg::make_negative(req_sid, udr_pkg::NRC_SERVICE);
            endcase
          end
        end
        udr_pkg::OP_TICK: begin
          quiet_nxt = quiet_inc;
          if (session_r != udr_pkg::DEFAULT_SESSION && quiet_inc > timeout_r)
            session_nxt = udr_pkg::DEFAULT_SESSION;
        end
        default: ;
      endcase
    end
  end

  assign push       = (rep.byte_cnt != '0);
  assign push_reply = rep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      session_r    <= udr_pkg::DEFAULT_SESSION;
      quiet_r      <= '0;
      slot_valid_r <= '0;
    end else begin
      session_r <= session_nxt;
      quiet_r   <= quiet_nxt;
      if (accept && operation == udr_pkg::OP_UPDATE) begin
        for (int i = 0; i < VALUE_SLOTS; i++) begin
          if (32'(value_slot) == i) slot_valid_r[i] <= value_valid;
        end
      end
    end
  end

  // stored words carry no reset, only read behind their valid bit
  always_ff @(posedge clk) begin
    if (accept && operation == udr_pkg::OP_UPDATE) begin
      for (int i = 0; i < VALUE_SLOTS; i++) begin
        if (32'(value_slot) == i) slot_value_r[i] <= value_bits;
      end
    end
  end

endmodule

@@ rtl/udr_queue.sv @@
// reply queue between front and back end
`timescale 1ns / 1ps

module udr_queue #(
  parameter int DEPTH = udr_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  udr_pkg::reply_t      push_reply,
  input  logic                 pop,
  output logic                 full,
  output udr_pkg::queue_head_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  udr_pkg::reply_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full       = (cnt_r == CW'(DEPTH));
  assign do_push    = push && !full;
  assign do_pop     = pop && (cnt_r != '0);
  assign head.valid = (cnt_r != '0);
  assign head.reply = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push)
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      if (do_pop)
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      if (do_push && !do_pop)
        cnt_r <= cnt_r + CW'(1);
      else if (do_pop && !do_push)
        cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_reply;
  end

endmodule

@@ rtl/udr_back.sv @@
// back end: sends queued replies one byte per transfer
`timescale 1ns / 1ps

module udr_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  udr_pkg::queue_head_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_resp_byte,
  output logic                 out_last_byte,
  output logic                 out_positive
);

  udr_pkg::reply_t cur_r;
  logic [2:0]      idx_r;
  logic            busy_r;
  logic            out_valid_r;
  logic [7:0]      byte_r;
  logic            last_r, pos_r;
  logic            advance, cur_last;

  assign advance  = !out_valid_r || !out_stall;
  assign cur_last = (idx_r == cur_r.byte_cnt - 3'd1);
  assign pop      = advance && !busy_r && head.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      busy_r      <= 1'b0;
    end else if (advance) begin
      if (busy_r) begin
        out_valid_r <= 1'b1;
        busy_r      <= !cur_last;
      end else if (head.valid) begin
        out_valid_r <= 1'b1;
        busy_r      <= (head.reply.byte_cnt != 3'd1);
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (busy_r) begin
        byte_r <= cur_r.data[idx_r];
        last_r <= cur_last;
        pos_r  <= cur_r.positive;
        idx_r  <= idx_r + 3'd1;
      end else if (head.valid) begin
        cur_r  <= head.reply;
        byte_r <= head.reply.data[0];
        last_r <= (head.reply.byte_cnt == 3'd1);
        pos_r  <= head.reply.positive;
        idx_r  <= 3'd1;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_resp_byte = byte_r;
  assign out_last_byte = last_r;
  assign out_positive  = pos_r;

endmodule

@@ rtl/uds_diagnostic_responder_top.sv @@
// diagnostic responder top level: front end, reply queue, byte sender
`timescale 1ns / 1ps

// path: the first reply byte goes through the reply queue and the output register
// throughput: one item per cycle while the reply queue has room; the byte sender
//   moves one reply byte per cycle while the output does not stall, so a request's rate
//   is set by its 2, 3 or 7 reply bytes; ticks, updates and silent requests push none
// reset: synchronous, active low; session returns to default, quiet counter,
//   value valid bits, queue and output clear, registers take reset values

module uds_diagnostic_responder_top #(
  parameter int VALUE_SLOTS = udr_pkg::VALUE_SLOTS,
  parameter int QUEUE_DEPTH = udr_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // item channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_req_sid,
  input  logic [7:0]  in_req_byte_one,
  input  logic [7:0]  in_req_byte_two,
  input  logic [11:0] in_request_length,
  input  logic [1:0]  in_value_slot,
  input  logic [31:0] in_value_bits,
  input  logic        in_value_valid,
  // reply byte channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_resp_byte,
  output logic        out_last_byte,
  output logic        out_positive
);

  logic                 accept;
  logic                 push;
  logic                 q_full;
  logic                 pop;
  udr_pkg::reply_t      push_reply;
  udr_pkg::queue_head_t head;

  // hold off new items only while the queue cannot take a reply
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // state updates and reply building happen in the transfer cycle
  udr_front #(
    .VALUE_SLOTS (VALUE_SLOTS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .accept         (accept),
    .operation      (in_operation),
    .req_sid        (in_req_sid),
    .req_byte_one   (in_req_byte_one),
    .req_byte_two   (in_req_byte_two),
    .request_length (in_request_length),
    .value_slot     (in_value_slot),
    .value_bits     (in_value_bits),
    .value_valid    (in_value_valid),
    .push           (push),
    .push_reply     (push_reply)
  );

  // decouples item intake from byte sending
  udr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_reply (push_reply),
    .pop        (pop),
    .full       (q_full),
    .head       (head)
  );

  // registered output, one reply byte per transfer
  udr_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_resp_byte (out_resp_byte),
    .out_last_byte (out_last_byte),
    .out_positive  (out_positive)
  );

endmodule

@@ rtl/udr_checker.sv @@
// port-level checks for the diagnostic responder, bound to the top level
`timescale 1ns / 1ps

module udr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_resp_byte,
  input logic       out_last_byte,
  input logic       out_positive
);

  logic first_r;
  logic out_xfer;

  assign out_xfer = out_valid && !out_stall;

  // marks the opening byte of each reply
  always_ff @(posedge clk) begin
    if (!rst_n) first_r <= 1'b1;
    else if (out_xfer) first_r <= out_last_byte;
  end

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("reply byte shown right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_resp_byte)
      && $stable(out_last_byte) && $stable(out_positive))
    else $error("stalled reply byte changed");

  a_reply_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && !out_last_byte |=> out_valid && (out_positive == $past(out_positive)))
    else $error("reply broken or polarity changed mid reply");

  a_negative_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && first_r && !out_positive |-> out_resp_byte == udr_pkg::RSP_NEGATIVE)
    else $error("negative reply does not open with the negative header");

endmodule

bind uds_diagnostic_responder_top udr_checker u_udr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_resp_byte (out_resp_byte),
  .out_last_byte (out_last_byte),
  .out_positive  (out_positive)
);
